@@ rtl/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and font table of the text glyph rectangle
// generator.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int COORD_BITS_DEF = 16;

	localparam int FONT_ROWS   = 7;
	localparam int FONT_COLS   = 5;
	localparam int FONT_CELLS  = FONT_ROWS * FONT_COLS;
	localparam int FONT_GLYPHS = 42;
	localparam int CELL_W      = 6;
	localparam int ROW_W       = 3;
	localparam int COL_W       = 3;
	localparam int GLYPH_W     = 6;
	localparam int OFF_W       = 8;

	localparam int ORIGIN_W = 12;
	localparam int SCALE_W  = 4;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CHAR_W   = 8;
	localparam int OUT_XY_W = 16;
	localparam int OUT_WH_W = 6;

	localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST = 12'd18;
	localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST = 12'd18;
	localparam logic [SCALE_W-1:0]  SCALE_RST    = 4'd2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOW_Z   = 8'h7A;
	localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UP_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_DIG_0   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_DIG_9   = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_BAR     = 8'h7C;
	localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

	localparam logic [GLYPH_W-1:0] GLYPH_DIG_BASE = 6'd26;
	localparam logic [GLYPH_W-1:0] GLYPH_COLON    = 6'd36;
	localparam logic [GLYPH_W-1:0] GLYPH_PERIOD   = 6'd37;
	localparam logic [GLYPH_W-1:0] GLYPH_SLASH    = 6'd38;
	localparam logic [GLYPH_W-1:0] GLYPH_BAR      = 6'd39;
	localparam logic [GLYPH_W-1:0] GLYPH_COMMA    = 6'd40;
	localparam logic [GLYPH_W-1:0] GLYPH_MINUS    = 6'd41;

	localparam logic [7:0] LINE_STEP  = 8'd9;
	localparam logic [7:0] CHAR_STEP  = 8'd6;
	localparam logic [7:0] BLOCK_H    = 8'd3;
	localparam logic [7:0] BLOCK_DROP = 8'd2;

	// bit 4 of a row is the leftmost column
	localparam logic [FONT_COLS-1:0] FONT_ROM [FONT_GLYPHS][FONT_ROWS] = '{
		'{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		'{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
		'{5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F},
		'{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
		'{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
		'{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0F,5'h10,5'h10,5'h13,5'h11,5'h11,5'h0F},
		'{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		'{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F},
		'{5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C},
		'{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
		'{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
		'{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
		'{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		'{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		'{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
		'{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
		'{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
		'{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		'{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		'{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
		'{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A},
		'{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		'{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		'{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
		'{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
		'{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		'{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F},
		'{5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E},
		'{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
		'{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
		'{5'h0F,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
		'{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		'{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
		'{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h1E},
		'{5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00},
		'{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C},
		'{5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10},
		'{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		'{5'h00,5'h00,5'h00,5'h00,5'h04,5'h04,5'h08},
		'{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}
	};

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_GLYPH,
		KIND_BLOCK
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BLOCK
	} state_t;

	typedef struct packed {
		logic hit;
		logic [GLYPH_W-1:0] idx;
	} glyph_ref_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit_cell;
		logic emit_block;
		logic advance;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  cell_lit;
		logic  cell_last;
		logic  out_free;
	} sts_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
			r = c - CHAR_CASE;
		end
		return r;
	endfunction

	function automatic glyph_ref_t glyph_lookup(input logic [CHAR_W-1:0] c);
		glyph_ref_t g;
		logic [CHAR_W-1:0] d;
		g.hit = 1'b1;
		g.idx = '0;
		d = '0;
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			d = c - CHAR_UP_A;
			g.idx = d[GLYPH_W-1:0];
		end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			d = c - CHAR_DIG_0;
			g.idx = GLYPH_DIG_BASE + d[GLYPH_W-1:0];
		end else begin
			case (c)
				CHAR_COLON:  g.idx = GLYPH_COLON;
				CHAR_PERIOD: g.idx = GLYPH_PERIOD;
				CHAR_SLASH:  g.idx = GLYPH_SLASH;
				CHAR_BAR:    g.idx = GLYPH_BAR;
				CHAR_COMMA:  g.idx = GLYPH_COMMA;
				CHAR_MINUS:  g.idx = GLYPH_MINUS;
				default:     g.hit = 1'b0;
			endcase
		end
		return g;
	endfunction

	// cell k = row * FONT_COLS + col
	function automatic logic [FONT_CELLS-1:0] glyph_cells(input logic [GLYPH_W-1:0] idx);
		logic [FONT_CELLS-1:0] cells;
		cells = '0;
		if (idx < GLYPH_W'(FONT_GLYPHS)) begin
			for (int r = 0; r < FONT_ROWS; r++) begin
				for (int c = 0; c < FONT_COLS; c++) begin
					cells[r*FONT_COLS+c] = FONT_ROM[idx][r][FONT_COLS-1-c];
				end
			end
		end
		return cells;
	endfunction

	function automatic logic [CELL_W-1:0] last_cell(input logic [FONT_CELLS-1:0] cells);
		logic [CELL_W-1:0] k;
		k = '0;
		for (int i = 0; i < FONT_CELLS; i++) begin
			if (cells[i]) begin
				k = CELL_W'(i);
			end
		end
		return k;
	endfunction

endpackage

@@ rtl/tgr_if.sv @@
// ----------------------------------------------------------------------------
// tgr_if
// Valid/ready channels for character input and rectangle output.
// ----------------------------------------------------------------------------
interface tgr_in_if;
	logic                         valid;
	logic                         ready;
	logic [tgr_pkg::CHAR_W-1:0]   char_code;
	logic                         text_start;

	modport source (output valid, output char_code, output text_start, input ready);
	modport sink   (input valid, input char_code, input text_start, output ready);
endinterface

interface tgr_out_if;
	logic                           valid;
	logic                           ready;
	logic [tgr_pkg::OUT_XY_W-1:0]   rect_x;
	logic [tgr_pkg::OUT_XY_W-1:0]   rect_y;
	logic [tgr_pkg::OUT_WH_W-1:0]   rect_w;
	logic [tgr_pkg::OUT_WH_W-1:0]   rect_h;
	logic                           last_rect;

	modport source (output valid, output rect_x, output rect_y, output rect_w,
		output rect_h, output last_rect, input ready);
	modport sink   (input valid, input rect_x, input rect_y, input rect_w,
		input rect_h, input last_rect, output ready);
endinterface

@@ rtl/tgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer: accepts a character, then walks the glyph cells or emits the
// unknown-character block, at most one rectangle per cycle.
// ----------------------------------------------------------------------------
module tgr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tgr_pkg::sts_t   sts,
	output tgr_pkg::cmd_t   cmd
);

	tgr_pkg::state_t state_q;
	tgr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tgr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (sts.kind)
						tgr_pkg::KIND_GLYPH: state_d = tgr_pkg::ST_SCAN;
						tgr_pkg::KIND_BLOCK: state_d = tgr_pkg::ST_BLOCK;
						default:             state_d = tgr_pkg::ST_IDLE;
					endcase
				end
			end
			tgr_pkg::ST_SCAN: begin
				// skip dark cells; a lit cell waits for room in the output register
				if (!sts.cell_lit) begin
					cmd.step = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit_cell = 1'b1;
					if (sts.cell_last) begin
						cmd.advance = 1'b1;
						state_d     = tgr_pkg::ST_IDLE;
					end else begin
						cmd.step = 1'b1;
					end
				end
			end
			tgr_pkg::ST_BLOCK: begin
				if (sts.out_free) begin
					cmd.emit_block = 1'b1;
					cmd.advance    = 1'b1;
					state_d        = tgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tgr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/tgr_dp.sv @@
// ----------------------------------------------------------------------------
// tgr_dp
// Datapath: configuration registers, text cursor, glyph cell walker and the
// rectangle output register.
// ----------------------------------------------------------------------------
module tgr_dp #(
	parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgr_pkg::CFG_W-1:0]     cfg_data,
	input  logic [tgr_pkg::CHAR_W-1:0]    char_code,
	input  logic                          text_start,
	input  tgr_pkg::cmd_t                 cmd,
	output tgr_pkg::sts_t                 sts,
	tgr_out_if.source                     out_ch
);

	localparam int CW = COORD_BITS;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
		input logic [tgr_pkg::OFF_W-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + (CW+1)'(b);
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	function automatic logic [tgr_pkg::OUT_XY_W-1:0] to_out(input logic [CW-1:0] v);
		logic [CW+tgr_pkg::OUT_XY_W-1:0] t;
		t = {{tgr_pkg::OUT_XY_W{1'b0}}, v};
		return t[tgr_pkg::OUT_XY_W-1:0];
	endfunction

	function automatic logic [CW-1:0] from_origin(input logic [tgr_pkg::ORIGIN_W-1:0] v);
		logic [CW+tgr_pkg::ORIGIN_W-1:0] t;
		t = {{CW{1'b0}}, v};
		return t[CW-1:0];
	endfunction

	logic [tgr_pkg::ORIGIN_W-1:0]  origin_x_q;
	logic [tgr_pkg::ORIGIN_W-1:0]  origin_y_q;
	logic [tgr_pkg::SCALE_W-1:0]   scale_q;
	logic [CW-1:0]                 cursor_x_q;
	logic [CW-1:0]                 cursor_y_q;
	logic [tgr_pkg::FONT_CELLS-1:0] glyph_q;
	logic [tgr_pkg::CELL_W-1:0]    last_cell_q;
	logic [tgr_pkg::CELL_W-1:0]    cell_q;
	logic [tgr_pkg::COL_W-1:0]     col_q;
	logic [tgr_pkg::OFF_W-1:0]     col_off_q;
	logic [tgr_pkg::OFF_W-1:0]     row_off_q;
	logic                          out_valid_q;
	logic [tgr_pkg::OUT_XY_W-1:0]  rect_x_q;
	logic [tgr_pkg::OUT_XY_W-1:0]  rect_y_q;
	logic [tgr_pkg::OUT_WH_W-1:0]  rect_w_q;
	logic [tgr_pkg::OUT_WH_W-1:0]  rect_h_q;
	logic                          last_rect_q;

	logic [tgr_pkg::SCALE_W-1:0]   scale_eff;
	logic [tgr_pkg::OFF_W-1:0]     scale_w;
	logic [tgr_pkg::OFF_W-1:0]     char_adv;
	logic [tgr_pkg::OFF_W-1:0]     line_adv;
	logic [tgr_pkg::OFF_W-1:0]     block_drop;
	logic [tgr_pkg::OFF_W-1:0]     block_h;
	logic [tgr_pkg::CHAR_W-1:0]    code_f;
	tgr_pkg::glyph_ref_t           gref;
	logic [tgr_pkg::FONT_CELLS-1:0] cells_in;
	logic [CW-1:0]                 base_x;
	logic [CW-1:0]                 base_y;
	logic                          out_take;

	always_comb begin
		scale_eff  = (scale_q == '0) ? tgr_pkg::SCALE_W'(1) : scale_q;
		scale_w    = tgr_pkg::OFF_W'(scale_eff);
		char_adv   = scale_w * tgr_pkg::CHAR_STEP;
		line_adv   = scale_w * tgr_pkg::LINE_STEP;
		block_drop = scale_w * tgr_pkg::BLOCK_DROP;
		block_h    = scale_w * tgr_pkg::BLOCK_H;
		code_f     = tgr_pkg::fold_case(char_code);
		gref       = tgr_pkg::glyph_lookup(code_f);
		cells_in   = tgr_pkg::glyph_cells(gref.idx);
		base_x     = text_start ? from_origin(origin_x_q) : cursor_x_q;
		base_y     = text_start ? from_origin(origin_y_q) : cursor_y_q;
		out_take   = out_valid_q && out_ch.ready;
	end

	always_comb begin
		if (code_f == tgr_pkg::CHAR_NEWLINE || code_f == tgr_pkg::CHAR_SPACE) begin
			sts.kind = tgr_pkg::KIND_NONE;
		end else if (gref.hit) begin
			sts.kind = tgr_pkg::KIND_GLYPH;
		end else begin
			sts.kind = tgr_pkg::KIND_BLOCK;
		end
		sts.cell_lit  = glyph_q[cell_q];
		sts.cell_last = (cell_q == last_cell_q);
		sts.out_free  = !out_valid_q || out_ch.ready;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= tgr_pkg::ORIGIN_X_RST;
			origin_y_q <= tgr_pkg::ORIGIN_Y_RST;
			scale_q    <= tgr_pkg::SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tgr_pkg::CFG_ORIGIN_X:    origin_x_q <= cfg_data[tgr_pkg::ORIGIN_W-1:0];
				tgr_pkg::CFG_ORIGIN_Y:    origin_y_q <= cfg_data[tgr_pkg::ORIGIN_W-1:0];
				tgr_pkg::CFG_PIXEL_SCALE: scale_q    <= cfg_data[tgr_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// text cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= from_origin(tgr_pkg::ORIGIN_X_RST);
			cursor_y_q <= from_origin(tgr_pkg::ORIGIN_Y_RST);
		end else if (cmd.load) begin
			if (code_f == tgr_pkg::CHAR_NEWLINE) begin
				cursor_x_q <= from_origin(origin_x_q);
				cursor_y_q <= sat_add(base_y, line_adv);
			end else if (code_f == tgr_pkg::CHAR_SPACE) begin
				cursor_x_q <= sat_add(base_x, char_adv);
				cursor_y_q <= base_y;
			end else begin
				cursor_x_q <= base_x;
				cursor_y_q <= base_y;
			end
		end else if (cmd.advance) begin
			cursor_x_q <= sat_add(cursor_x_q, char_adv);
		end
	end

	// cell walker
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q     <= cells_in;
			last_cell_q <= tgr_pkg::last_cell(cells_in);
			cell_q      <= '0;
			col_q       <= '0;
			col_off_q   <= '0;
			row_off_q   <= '0;
		end else if (cmd.step) begin
			cell_q <= cell_q + 1'b1;
			if (col_q == tgr_pkg::COL_W'(tgr_pkg::FONT_COLS - 1)) begin
				col_q     <= '0;
				col_off_q <= '0;
				row_off_q <= row_off_q + scale_w;
			end else begin
				col_q     <= col_q + 1'b1;
				col_off_q <= col_off_q + scale_w;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cell || cmd.emit_block) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cell) begin
			rect_x_q    <= to_out(sat_add(cursor_x_q, col_off_q));
			rect_y_q    <= to_out(sat_add(cursor_y_q, row_off_q));
			rect_w_q    <= tgr_pkg::OUT_WH_W'(scale_eff);
			rect_h_q    <= tgr_pkg::OUT_WH_W'(scale_eff);
			last_rect_q <= sts.cell_last;
		end else if (cmd.emit_block) begin
			rect_x_q    <= to_out(cursor_x_q);
			rect_y_q    <= to_out(sat_add(cursor_y_q, block_drop));
			rect_w_q    <= tgr_pkg::OUT_WH_W'({scale_eff, 2'b00});
			rect_h_q    <= block_h[tgr_pkg::OUT_WH_W-1:0];
			last_rect_q <= 1'b1;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.rect_x    = rect_x_q;
	assign out_ch.rect_y    = rect_y_q;
	assign out_ch.rect_w    = rect_w_q;
	assign out_ch.rect_h    = rect_h_q;
	assign out_ch.last_rect = last_rect_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_cell || cmd.emit_block) |-> (!out_valid_q || out_ch.ready))
		else $error("rectangle emitted while output register held an untaken one");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cell_q < last_cell_q))
		else $error("cell walker stepped past the last lit cell");

	a_load_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(cmd.emit_cell || cmd.emit_block || cmd.advance || cmd.step))
		else $error("character load overlapped other datapath work");

	a_last_advances: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.emit_cell && sts.cell_last) || cmd.emit_block) |-> cmd.advance)
		else $error("final rectangle emitted without cursor advance");

endmodule

@@ rtl/text_glyph_rect_generator_core.sv @@
// ----------------------------------------------------------------------------
// text_glyph_rect_generator_core
// 5x7 character generator: turns character codes into pixel rectangles and
// keeps the text cursor.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    char_code[7:0], text_start
//   out_ch   out  valid/ready    rect_x[15:0], rect_y[15:0], rect_w[5:0],
//                                rect_h[5:0], last_rect
//   cfg      in   cfg_we         cfg_index[1:0], cfg_data[11:0]
//
// Newline and space finish as the character is taken. A glyph then walks its
// cells one per cycle up to its last lit cell, as long as the output has room
// for each lit cell. An unknown character is taken and then emits its block.
// A stalled output holds the walk on a lit cell; the next character is taken
// while the final rectangle still waits.
// Reset loads the default origin and scale and puts the cursor at the origin.
// ----------------------------------------------------------------------------
module text_glyph_rect_generator_core #(
	parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tgr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tgr_pkg::CFG_W-1:0]     cfg_data,
	tgr_in_if.sink                        in_ch,
	tgr_out_if.source                     out_ch
);

	tgr_pkg::cmd_t cmd;
	tgr_pkg::sts_t sts;

	tgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgr_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_code  (in_ch.char_code),
		.text_start (in_ch.text_start),
		.cmd        (cmd),
		.sts        (sts),
		.out_ch     (out_ch)
	);

endmodule
